@@ hw/rtl/filmic_tone_map_rgb_assert.svh @@
// assertion macros shared by the tone mapper rtl
`ifndef FILMIC_TONE_MAP_RGB_ASSERT_SVH
`define FILMIC_TONE_MAP_RGB_ASSERT_SVH

// condition implies consequence in the same cycle, quiet during reset
`define FTM_ASSERT_NOW(lbl, clk, rst_n, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("tone map check failed");

// condition implies consequence in the next cycle, checked through reset
`define FTM_ASSERT_NEXT(lbl, clk, cond, cons) \
    lbl: assert property (@(posedge clk) (cond) |=> (cons)) \
        else $error("tone map check failed");

`endif

@@ hw/rtl/ftm_pkg.sv @@
// constants shared by the filmic tone mapper
package ftm_pkg;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int NCH              = 3;
    localparam int CFG_W            = 16;
    localparam int CFG_IDX_W        = 2;
    localparam int Q_BITS           = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_EXPOSURE_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_WHITE      = 2'd1;

    localparam logic [CFG_W-1:0] GAIN_RESET      = 16'd4096;
    localparam logic [CFG_W-1:0] INV_WHITE_RESET = 16'd5130;
endpackage

@@ hw/rtl/filmic_tone_map_rgb.sv @@
// filmic tone mapper: exposure, hable curve, white scaling, three channels in parallel
//
// channel  dir  tdata (low bit up)                         tuser
// s_axis   in   red_in, green_in, blue_in                  -
// m_axis   out  red_out, green_out, blue_out               clipped
// cfg      in   i_cfg_idx 0 exposure_gain, 1 inverse_white_scale
//
// the pipeline runs exposure and curve terms, then the one bit per stage
// divider, then white scaling and saturation
// one pixel per clock; a stall backs up only until a bubble is found
// i_rst_n clears all valid bits; config registers return to their defaults
module filmic_tone_map_rgb #(
    parameter int SAMPLE_WIDTH = ftm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [ftm_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [ftm_pkg::CFG_W-1:0]              i_cfg_data,
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // red_in, green_in, blue_in, zero pad
    input  logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0]    i_s_axis_tdata,
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // red_out, green_out, blue_out, zero pad
    output logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0]    o_m_axis_tdata,
    // clipped
    output logic                                   o_m_axis_tuser
);
    import ftm_pkg::*;
    `include "filmic_tone_map_rgb_assert.svh"

    localparam int SW   = SAMPLE_WIDTH;
    localparam int TDW  = ((3*SW+7)/8)*8;
    localparam int PW   = SW + CFG_W;
    localparam int XRW  = PW - 11;
    localparam int KW   = SW + 8;
    localparam int DW   = 2*SW + 9;
    localparam int SQW  = 2*SW;
    localparam int MW   = Q_BITS + CFG_W;
    localparam int OSH  = 44 - SW;
    localparam int ORW  = MW + 1 - OSH;
    localparam int DIV0 = 4;
    localparam int SCL  = DIV0 + Q_BITS;
    localparam int NST  = SCL + 2;

    localparam logic [SW-1:0] CH_MAX = {SW{1'b1}};

    logic [CFG_W-1:0] r_gain;
    logic [CFG_W-1:0] r_inv;

    logic [NST-1:0] r_v;
    logic [NST-1:0] r_clp;
    logic [NST:0]   w_free;

    logic [PW-1:0]     r_prod [NCH];
    logic [SW-1:0]     r_x    [NCH];
    logic [SW-1:0]     r_x2   [NCH];
    logic [DW-1:0]     r_n2   [NCH];
    logic [SQW-1:0]    r_sq   [NCH];
    logic [DW-1:0]     r_num  [NCH];
    logic [DW-1:0]     r_den  [NCH];
    logic [DW-1:0]     r_rem  [Q_BITS][NCH];
    logic [DW-1:0]     r_dvd  [Q_BITS][NCH];
    logic [Q_BITS-1:0] r_quo  [Q_BITS][NCH];
    logic [MW-1:0]     r_scl  [NCH];
    logic [SW-1:0]     r_out  [NCH];

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
            r_inv  <= INV_WHITE_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_EXPOSURE_GAIN) begin
                r_gain <= i_cfg_data;
            end else if (i_cfg_idx == CFG_INV_WHITE) begin
                r_inv <= i_cfg_data;
            end
        end
    end

    // a stage may load when it is empty or its item moves on
    always_comb begin
        w_free[NST] = i_m_axis_tready;
        for (int k = NST-1; k >= 0; k--) begin
            w_free[k] = !r_v[k] || w_free[k+1];
        end
    end

    assign o_s_axis_tready = w_free[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_free[0]) begin
                r_v[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_free[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // datapath
    logic [XRW-1:0] n_xr  [NCH];
    logic [NCH-1:0] n_xsat;
    logic [KW-1:0]  n_k   [NCH];
    logic [DW-1:0]  n_c   [NCH];
    logic [DW:0]    n_t   [Q_BITS][NCH];
    logic [DW:0]    n_td  [Q_BITS][NCH];
    logic [DW-1:0]  n_rin [Q_BITS][NCH];
    logic [DW-1:0]  n_din [Q_BITS][NCH];
    logic [Q_BITS-1:0] n_qin [Q_BITS][NCH];
    logic [ORW-1:0] n_or  [NCH];
    logic [NCH-1:0] n_osat;

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            n_xr[c]   = XRW'(({1'b0, r_prod[c]} + (PW+1)'(2048)) >> 12);
            n_xsat[c] = |n_xr[c][XRW-1:SW];
            n_k[c]    = KW'(r_x[c]) * KW'(210) + (KW'(25) << (SW-4));
            n_c[c]    = DW'(r_sq[c]) * DW'(15) + ((DW'(r_x2[c]) * DW'(50)) << (SW-4))
                        + (DW'(6) << (2*SW-8));
            for (int j = 0; j < Q_BITS; j++) begin
                if (j == 0) begin
                    n_rin[j][c] = r_num[c];
                    n_din[j][c] = r_den[c];
                    n_qin[j][c] = '0;
                end else begin
                    n_rin[j][c] = r_rem[j-1][c];
                    n_din[j][c] = r_dvd[j-1][c];
                    n_qin[j][c] = r_quo[j-1][c];
                end
                n_t[j][c]  = {n_rin[j][c], 1'b0};
                n_td[j][c] = n_t[j][c] - {1'b0, n_din[j][c]};
            end
            n_or[c]   = ORW'(({1'b0, r_scl[c]} + ((MW+1)'(1) << (OSH-1))) >> OSH);
            n_osat[c] = |n_or[c][ORW-1:SW];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < NCH; c++) begin
            if (w_free[0]) begin
                r_prod[c] <= PW'(i_s_axis_tdata[c*SW +: SW]) * PW'(r_gain);
            end
            if (w_free[1]) begin
                r_x[c] <= n_xsat[c] ? CH_MAX : n_xr[c][SW-1:0];
            end
            if (w_free[2]) begin
                r_n2[c] <= DW'(r_x[c]) * DW'(n_k[c]);
                r_sq[c] <= SQW'(r_x[c]) * SQW'(r_x[c]);
                r_x2[c] <= r_x[c];
            end
            if (w_free[3]) begin
                r_num[c] <= r_n2[c];
                r_den[c] <= (n_c[c] << 4) - n_c[c];
            end
            // one restoring divide step per stage
            for (int j = 0; j < Q_BITS; j++) begin
                if (w_free[DIV0+j]) begin
                    r_dvd[j][c] <= n_din[j][c];
                    if (!n_td[j][c][DW]) begin
                        r_rem[j][c] <= n_td[j][c][DW-1:0];
                        r_quo[j][c] <= {n_qin[j][c][Q_BITS-2:0], 1'b1};
                    end else begin
                        r_rem[j][c] <= n_t[j][c][DW-1:0];
                        r_quo[j][c] <= {n_qin[j][c][Q_BITS-2:0], 1'b0};
                    end
                end
            end
            if (w_free[SCL]) begin
                r_scl[c] <= MW'(r_quo[Q_BITS-1][c]) * MW'(r_inv);
            end
            if (w_free[SCL+1]) begin
                r_out[c] <= n_osat[c] ? CH_MAX : n_or[c][SW-1:0];
            end
        end
    end

    // clip flag travels with the item
    always_ff @(posedge i_clk) begin
        if (w_free[0]) begin
            r_clp[0] <= 1'b0;
        end
        if (w_free[1]) begin
            r_clp[1] <= r_clp[0] | (|n_xsat);
        end
        for (int k = 2; k < NST-1; k++) begin
            if (w_free[k]) begin
                r_clp[k] <= r_clp[k-1];
            end
        end
        if (w_free[NST-1]) begin
            r_clp[NST-1] <= r_clp[NST-2] | (|n_osat);
        end
    end

    always_comb begin
        o_m_axis_tdata = '0;
        for (int c = 0; c < NCH; c++) begin
            o_m_axis_tdata[c*SW +: SW] = r_out[c];
        end
    end

    assign o_m_axis_tvalid = r_v[NST-1];
    assign o_m_axis_tuser  = r_clp[NST-1];

    // input is refused only when every stage holds an item
    `FTM_ASSERT_NOW(a_full_when_blocked, i_clk, i_rst_n, !o_s_axis_tready, &r_v)
    // curve ratio stays below one
    `FTM_ASSERT_NOW(a_num_below_den, i_clk, i_rst_n, r_v[DIV0-1], r_num[0] < r_den[0])
    // final green channel divider remainder stays below the divisor
    `FTM_ASSERT_NOW(a_rem_below_den, i_clk, i_rst_n, r_v[SCL-1],
        r_rem[Q_BITS-1][1] < r_dvd[Q_BITS-1][1])
    // reset empties the pipeline
    `FTM_ASSERT_NEXT(a_reset_empty, i_clk, !i_rst_n, !o_m_axis_tvalid && r_v == '0)
endmodule

@@ tb/sv/filmic_tone_map_rgb_tb.sv @@
// self-checking testbench for the filmic tone mapper: random pixels, config phases, stalls
module filmic_tone_map_rgb_tb;
    import ftm_pkg::*;

    localparam int SW    = 16;
    localparam int DW    = ((3*SW+7)/8)*8;
    localparam int LAT   = 38;
    localparam int LIMIT = 400000;

    typedef struct packed {
        logic [SW-1:0] blue;
        logic [SW-1:0] green;
        logic [SW-1:0] red;
    } pixel_t;

    typedef struct {
        logic [SW-1:0] red;
        logic [SW-1:0] green;
        logic [SW-1:0] blue;
        logic          clipped;
    } mapped_t;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    logic          i_s_axis_tvalid;
    logic          o_s_axis_tready;
    logic [DW-1:0] i_s_axis_tdata;
    logic          o_m_axis_tvalid;
    logic          i_m_axis_tready;
    logic [DW-1:0] o_m_axis_tdata;
    logic          o_m_axis_tuser;

    filmic_tone_map_rgb uut (.*);

    pixel_t  pixel_queue[$];
    mapped_t mapped_queue[$];
    logic [CFG_W-1:0] gain_reg;
    logic [CFG_W-1:0] inv_white_reg;
    int      errors;
    int      cycles;
    bit      idle_on;
    int      hold_off;

    // one channel: exposure, exact curve ratio, restoring divide, white scaling
    function automatic logic [SW:0] map_channel(logic [SW-1:0] value);
        logic [63:0] s, x, n, d, rem, q, scaled;
        logic        clip;
        s    = 64'd1 << (SW-4);
        clip = 1'b0;
        x    = (64'(value) * 64'(gain_reg) + 64'd2048) >> 12;
        if (x > (64'd1 << SW) - 1) begin
            x    = (64'd1 << SW) - 1;
            clip = 1'b1;
        end
        n   = x * (210*x + 25*s);
        d   = 15 * (15*x*x + 50*x*s + 6*s*s);
        rem = n;
        q   = 0;
        for (int i = 0; i < Q_BITS; i++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= d) begin
                rem  = rem - d;
                q[0] = 1'b1;
            end
        end
        scaled = (q * 64'(inv_white_reg) + (64'd1 << (43-SW))) >> (44-SW);
        if (scaled > (64'd1 << SW) - 1) begin
            scaled = (64'd1 << SW) - 1;
            clip   = 1'b1;
        end
        return {clip, scaled[SW-1:0]};
    endfunction

    function automatic mapped_t tone_map(pixel_t p);
        mapped_t m;
        logic [SW:0] r, g, b;
        r = map_channel(p.red);
        g = map_channel(p.green);
        b = map_channel(p.blue);
        m.red     = r[SW-1:0];
        m.green   = g[SW-1:0];
        m.blue    = b[SW-1:0];
        m.clipped = r[SW] | g[SW] | b[SW];
        return m;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_EXPOSURE_GAIN) gain_reg = value;
        else if (idx == CFG_INV_WHITE) inv_white_reg = value;
    endtask

    function automatic logic [SW-1:0] rand_chan();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 8191));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_pixel(logic [SW-1:0] r, logic [SW-1:0] g, logic [SW-1:0] b);
        pixel_t p;
        p.red = r; p.green = g; p.blue = b;
        pixel_queue.push_back(p);
    endtask

    task automatic run_phase(int count);
        for (int i = 0; i < count; i++) queue_pixel(rand_chan(), rand_chan(), rand_chan());
        wait (pixel_queue.size() == 0 && mapped_queue.size() == 0);
        repeat (LAT + 4) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                mapped_queue.push_back(tone_map(pixel_t'(i_s_axis_tdata[3*SW-1:0])));
                void'(pixel_queue.pop_front());
            end
            if (i_s_axis_tvalid && !o_s_axis_tready) begin
                // an offered item stays put until it is taken
                i_s_axis_tvalid <= 1'b1;
            end else if (pixel_queue.size() > 0
                && (!idle_on || $urandom_range(0, 99) >= 33)) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= DW'(pixel_queue[0]);
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor and receiver
    always @(posedge i_clk) begin
        mapped_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (mapped_queue.size() == 0) begin
                report("unexpected item", 0, 0);
            end else begin
                want = mapped_queue.pop_front();
                if (o_m_axis_tdata[SW-1:0] !== want.red)
                    report("red", o_m_axis_tdata[SW-1:0], want.red);
                if (o_m_axis_tdata[2*SW-1:SW] !== want.green)
                    report("green", o_m_axis_tdata[2*SW-1:SW], want.green);
                if (o_m_axis_tdata[3*SW-1:2*SW] !== want.blue)
                    report("blue", o_m_axis_tdata[3*SW-1:2*SW], want.blue);
                if (o_m_axis_tuser !== want.clipped)
                    report("clipped", o_m_axis_tuser, want.clipped);
            end
        end
        if (hold_off > 0) begin
            hold_off        <= hold_off - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= !idle_on || $urandom_range(0, 99) >= 33;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        errors          = 0;
        cycles          = 0;
        idle_on         = 1'b0;
        hold_off        = 0;
        gain_reg        = GAIN_RESET;
        inv_white_reg   = INV_WHITE_RESET;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_EXPOSURE_GAIN;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes and zero cases at reset defaults
        queue_pixel(16'd0, 16'd0, 16'd0);
        queue_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_pixel(16'd4096, 16'd1, 16'h8000);
        queue_pixel(16'h5555, 16'hAAAA, 16'd0);
        queue_pixel(16'd2048, 16'd45875, 16'd12);
        run_phase(0);
        // full gain saturates the exposure product; big white scale saturates output
        write_reg(CFG_EXPOSURE_GAIN, 16'hFFFF);
        write_reg(CFG_INV_WHITE, 16'hFFFF);
        queue_pixel(16'hFFFF, 16'd1, 16'd0);
        queue_pixel(16'd16, 16'd4096, 16'h00FF);
        run_phase(0);
        // zero gain and zero white scale give zero outputs
        write_reg(CFG_EXPOSURE_GAIN, 16'd0);
        queue_pixel(16'hFFFF, 16'h1234, 16'd1);
        run_phase(0);
        write_reg(CFG_EXPOSURE_GAIN, GAIN_RESET);
        write_reg(CFG_INV_WHITE, 16'd0);
        queue_pixel(16'hFFFF, 16'h1234, 16'd1);
        run_phase(0);

        // random phases: no idling first, then idling, then a long receiver stall, then more config settings
        write_reg(CFG_INV_WHITE, INV_WHITE_RESET);
        run_phase(150);
        idle_on = 1'b1;
        write_reg(CFG_EXPOSURE_GAIN, 16'd8192);
        run_phase(150);
        hold_off = 300;
        for (int i = 0; i < 120; i++) queue_pixel(rand_chan(), rand_chan(), rand_chan());
        run_phase(0);
        write_reg(CFG_EXPOSURE_GAIN, 16'($urandom));
        write_reg(CFG_INV_WHITE, 16'($urandom));
        run_phase(130);
        write_reg(CFG_EXPOSURE_GAIN, 16'd1);
        write_reg(CFG_INV_WHITE, 16'hFFFF);
        run_phase(100);
        write_reg(CFG_EXPOSURE_GAIN, 16'($urandom_range(2048, 16384)));
        write_reg(CFG_INV_WHITE, 16'($urandom_range(4096, 8192)));
        run_phase(150);

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
